>>> src/hrle_pkg.sv
// ----------------------------------------------------------------------------
// hrle_pkg
// Shared types, constants and helpers for the S-record line encoder.
// ----------------------------------------------------------------------------
package hrle_pkg;

    // largest data byte count a record may carry
    localparam int unsigned MAX_DATA_BYTES_DEF = 250;

    // operation codes
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    // fixed characters
    localparam logic [6:0] CHAR_S       = 7'h53;
    localparam logic [6:0] CHAR_NEWLINE = 7'h0A;
    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_A       = 7'h41;

    // bytes held by one character job: count, up to four address bytes, checksum
    localparam int unsigned JOB_BYTES = 6;

    // input transaction
    typedef struct packed {
        logic        operation;
        logic [3:0]  record_type;
        logic [31:0] address;
        logic [7:0]  byte_count;
        logic [7:0]  data_byte;
    } in_item_t;

    // output transaction
    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last_of_run;
    } out_item_t;

    // characters owed for one input transaction
    typedef struct packed {
        logic                       has_prefix;  // 'S' and type digit first
        logic [3:0]                 type_digit;
        logic [JOB_BYTES-1:0][7:0]  bytes;       // bytes[0] goes out first
        logic [2:0]                 num_bytes;
        logic [3:0]                 num_chars;   // total characters, 2..15
    } job_t;

    // upper-case hex digit of one nibble
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] res;
        if (nib < 4'd10)
        begin
            res = CHAR_ZERO + {3'b000, nib};
        end
        else
        begin
            res = CHAR_A + {3'b000, nib - 4'd10};
        end
        return res;
    endfunction

endpackage

>>> src/hrle_char_seq.sv
// ----------------------------------------------------------------------------
// hrle_char_seq
// Holds one character job and sends its characters, one per cycle while the
// output is not stalled, through the output register.
// ----------------------------------------------------------------------------
module hrle_char_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_load,
    input  hrle_pkg::job_t     job,
    output logic               job_free,
    output logic               out_valid,
    input  logic               out_stall,
    output hrle_pkg::out_item_t out_item
);
    import hrle_pkg::*;

    job_t       job_reg;
    logic       job_valid_reg;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       out_valid_reg;
    out_item_t  out_item_reg;

    logic       advance;
    logic       is_last;
    logic [3:0] body_idx;
    logic [7:0] cur_byte;
    logic [3:0] cur_nib;
    logic [6:0] cur_char;

    // step when a job waits and the output register is empty or draining
    assign advance  = job_valid_reg && (!out_valid_reg || !out_stall);
    assign is_last  = (idx_reg == job_reg.num_chars - 4'd1);
    assign job_free = !job_valid_reg || (advance && is_last);
    assign idx_next = is_last ? 4'd0 : idx_reg + 4'd1;

    // pick the current character
    always_comb
    begin
        body_idx = job_reg.has_prefix ? idx_reg - 4'd2 : idx_reg;
        cur_byte = job_reg.bytes[body_idx[3:1]];
        cur_nib  = body_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
        if (job_reg.has_prefix && idx_reg == 4'd0)
        begin
            cur_char = CHAR_S;
        end
        else if (job_reg.has_prefix && idx_reg == 4'd1)
        begin
            cur_char = hex_char(job_reg.type_digit);
        end
        else if (body_idx < {job_reg.num_bytes, 1'b0})
        begin
            cur_char = hex_char(cur_nib);
        end
        else
        begin
            cur_char = CHAR_NEWLINE;
        end
    end

    // job slot and character index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            if (advance)
            begin
                idx_reg <= idx_next;
                if (is_last)
                begin
                    job_valid_reg <= 1'b0;
                end
            end
            if (job_load)
            begin
                job_valid_reg <= 1'b1;
            end
        end
    end

    // job payload
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg.ascii_char  <= cur_char;
            out_item_reg.last_of_run <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> src/hex_record_line_encoder.sv
// ----------------------------------------------------------------------------
// hex_record_line_encoder
// S-record line encoder: header and data transactions in, ASCII characters
// of the record line out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_item  (hrle_pkg::in_item_t)
//  out     | output    | out_valid/out_stall | out_item (hrle_pkg::out_item_t)
//
//  One character leaves per cycle while out is not stalled; a transaction is
//  taken once the previous one is down to its final character, so a data byte
//  yields 2 characters (5 with checksum and newline) and a header 8 to 15.
//  Stray data and unknown record types are taken and produce no characters.
//  Reset clears the checksum, the open-record count and both valid flags.
//  A stall on out holds the current character and backs up into in_stall.
// ----------------------------------------------------------------------------
module hex_record_line_encoder #(
    parameter int unsigned MAX_DATA_BYTES = hrle_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  hrle_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output hrle_pkg::out_item_t out_item
);
    import hrle_pkg::*;

    localparam logic [7:0] MAX_BYTES = 8'(MAX_DATA_BYTES);

    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic [7:0] bytes_remaining_reg;
    logic [7:0] bytes_remaining_next;

    logic       accept;
    logic       job_free;
    logic       job_load;
    job_t       job;

    logic [2:0] addr_bytes;
    logic       type_ok;
    logic [7:0] count_clamped;
    logic [7:0] count_byte;
    logic [7:0] addr_b2;
    logic [7:0] addr_b3;
    logic [7:0] hdr_sum;
    logic [7:0] data_sum;
    logic       count_zero;
    logic       data_last;

    assign in_stall = !job_free;
    assign accept   = in_valid && !in_stall;

    // header field decode
    always_comb
    begin
        type_ok = 1'b1;
        case (in_item.record_type)
            4'd0, 4'd1, 4'd4, 4'd5, 4'd6, 4'd9: addr_bytes = 3'd2;
            4'd2, 4'd8:                         addr_bytes = 3'd3;
            4'd3, 4'd7:                         addr_bytes = 3'd4;
            default:
            begin
                addr_bytes = 3'd2;
                type_ok    = 1'b0;
            end
        endcase
        count_clamped = (in_item.byte_count > MAX_BYTES) ? MAX_BYTES : in_item.byte_count;
        count_byte    = count_clamped + {5'd0, addr_bytes} + 8'd1;
        addr_b2       = (addr_bytes >= 3'd3) ? in_item.address[23:16] : 8'd0;
        addr_b3       = (addr_bytes == 3'd4) ? in_item.address[31:24] : 8'd0;
        hdr_sum       = count_byte + addr_b3 + addr_b2
                        + in_item.address[15:8] + in_item.address[7:0];
        count_zero    = (count_clamped == 8'd0);
        data_sum      = running_sum_reg + in_item.data_byte;
        data_last     = (bytes_remaining_reg == 8'd1);
    end

    // build the character job and the next record state
    always_comb
    begin
        job                  = '0;
        job_load             = 1'b0;
        running_sum_next     = running_sum_reg;
        bytes_remaining_next = bytes_remaining_reg;
        if (in_item.operation == OP_HEADER)
        begin
            running_sum_next     = 8'd0;
            bytes_remaining_next = 8'd0;
            if (type_ok)
            begin
                job_load        = accept;
                job.has_prefix  = 1'b1;
                job.type_digit  = in_item.record_type;
                job.bytes[0]    = count_byte;
                case (addr_bytes)
                    3'd3:
                    begin
                        job.bytes[1] = in_item.address[23:16];
                        job.bytes[2] = in_item.address[15:8];
                        job.bytes[3] = in_item.address[7:0];
                        job.bytes[4] = ~hdr_sum;
                    end
                    3'd4:
                    begin
                        job.bytes[1] = in_item.address[31:24];
                        job.bytes[2] = in_item.address[23:16];
                        job.bytes[3] = in_item.address[15:8];
                        job.bytes[4] = in_item.address[7:0];
                        job.bytes[5] = ~hdr_sum;
                    end
                    default:
                    begin
                        job.bytes[1] = in_item.address[15:8];
                        job.bytes[2] = in_item.address[7:0];
                        job.bytes[3] = ~hdr_sum;
                    end
                endcase
                // checksum byte and newline only for an empty record
                job.num_bytes = addr_bytes + 3'd1 + {2'b00, count_zero};
                job.num_chars = 4'd2 + {job.num_bytes, 1'b0} + {3'b000, count_zero};
                running_sum_next = hdr_sum;
                bytes_remaining_next = count_clamped;
            end
        end
        else if (bytes_remaining_reg != 8'd0)
        begin
            job_load             = accept;
            job.bytes[0]         = in_item.data_byte;
            job.bytes[1]         = ~data_sum;
            job.num_bytes        = data_last ? 3'd2 : 3'd1;
            job.num_chars        = data_last ? 4'd5 : 4'd2;
            running_sum_next     = data_sum;
            bytes_remaining_next = bytes_remaining_reg - 8'd1;
        end
    end

    // record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg     <= 8'd0;
            bytes_remaining_reg <= 8'd0;
        end
        else if (accept)
        begin
            running_sum_reg     <= running_sum_next;
            bytes_remaining_reg <= bytes_remaining_next;
        end
    end

    // character sequencer and output register
    hrle_char_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_load  (job_load),
        .job       (job),
        .job_free  (job_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

>>> src/hrle_checker.sv
// ----------------------------------------------------------------------------
// hrle_checker
// Port-level checks for the S-record line encoder, bound to the top level.
// ----------------------------------------------------------------------------
module hrle_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input hrle_pkg::out_item_t out_item
);
    import hrle_pkg::*;

    // a stalled output transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a stalled output payload does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("out_item changed while stalled");

    // a newline always closes the run of an input transaction
    a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.ascii_char == CHAR_NEWLINE |-> out_item.last_of_run)
        else $error("newline not flagged as last of run");

    // 'S' always opens a line and is never the final character
    a_s_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.ascii_char == CHAR_S |-> !out_item.last_of_run)
        else $error("record start flagged as last of run");

    // characters of one run leave back to back
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_item.last_of_run |=> out_valid)
        else $error("gap inside a character run");

endmodule

bind hex_record_line_encoder hrle_checker u_hrle_checker (.*);
